@@ sv/acrd_pkg.sv @@
// Package for the annular current ring density block: widths, register
// indexes, reset values and the side-band type of the divider pipeline.
// No dependencies.
`default_nettype none
package acrd_pkg;

   localparam int CW     = 16;            // coordinate width
   localparam int FRAC   = 12;            // fractional bits
   localparam int DW     = CW + 1;        // coordinate difference
   localparam int PW     = 2 * DW;        // signed product of differences
   localparam int H2W    = PW;            // squared axis length, unsigned
   localparam int TW     = PW + 2;        // projection, signed
   localparam int XW     = PW + 1;        // cross product component, signed
   localparam int MW     = XW - 1;        // cross product magnitude
   localparam int CCW    = 2 * MW + 2;    // sum of squared cross components
   localparam int RW     = 16;            // radius
   localparam int RSQW   = 2 * RW;        // squared radius
   localparam int BW     = RSQW + H2W;    // radial band bound
   localparam int NUMW   = CW + MW;       // |I| * |c|
   localparam int DENW   = H2W + RW;      // h2 * (rb - ra)
   localparam int NW     = NUMW + FRAC + 1; // rounded dividend
   localparam int OW     = 24;            // density width
   localparam int QW     = OW;            // quotient bits produced
   localparam int EW     = DENW + QW;     // divider compare width
   localparam int RADW   = 31;            // ring radii register
   localparam int NREG   = 8;
   localparam int IDXW   = 3;

   localparam logic [IDXW-1:0] REG_START_X = 3'd0;
   localparam logic [IDXW-1:0] REG_START_Y = 3'd1;
   localparam logic [IDXW-1:0] REG_START_Z = 3'd2;
   localparam logic [IDXW-1:0] REG_END_X   = 3'd3;
   localparam logic [IDXW-1:0] REG_END_Y   = 3'd4;
   localparam logic [IDXW-1:0] REG_END_Z   = 3'd5;
   localparam logic [IDXW-1:0] REG_RADII   = 3'd6;
   localparam logic [IDXW-1:0] REG_CURRENT = 3'd7;

   localparam logic [CW-1:0]   END_X_RST   = 16'd8192;
   localparam logic [RADW-1:0] RADII_RST   = 31'd107348787;
   localparam logic [CW-1:0]   CURRENT_RST = 16'd4096;

   localparam logic [OW-1:0] PMAX = {1'b0, {(OW-1){1'b1}}};
   localparam logic [OW-1:0] NMAX = {1'b1, {(OW-1){1'b0}}};

   typedef struct packed {
      logic       in_ring;
      logic [2:0] neg;
   } side_type;

endpackage
`default_nettype wire

@@ sv/acrd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag when the quotient does not fit. Uses acrd_pkg.
`default_nettype none
module acrd_div (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [acrd_pkg::NW-1:0]    num,
   input  wire logic [acrd_pkg::DENW-1:0]  den,
   output logic      [acrd_pkg::QW-1:0]    quot,
   output logic                            ovf
);
   localparam int QW = acrd_pkg::QW;
   localparam int NW = acrd_pkg::NW;
   localparam int EW = acrd_pkg::EW;
   localparam int DENW = acrd_pkg::DENW;

   logic [NW-1:0]   rem_ff [QW];
   logic [DENW-1:0] den_ff [QW];
   logic [QW-1:0]   q_ff   [QW];
   logic            ovf_ff [QW];

   genvar j;
   generate
      for (j = 0; j < QW; j++) begin : g_stage
         logic [NW-1:0]   rem_src;
         logic [DENW-1:0] den_src;
         logic [QW-1:0]   q_src;
         logic            ovf_src;
         logic [EW-1:0]   trial;
         logic            ge;
         logic [NW-1:0]   rem_in;
         logic [QW-1:0]   q_in;
         if (j == 0) begin : g_first
            always_comb begin
               rem_src = num;
               den_src = den;
               q_src   = '0;
               ovf_src = EW'(num) >= (EW'(den) << QW);
            end
         end else begin : g_next
            always_comb begin
               rem_src = rem_ff[j-1];
               den_src = den_ff[j-1];
               q_src   = q_ff[j-1];
               ovf_src = ovf_ff[j-1];
            end
         end
         always_comb begin
            trial  = EW'(den_src) << (QW - 1 - j);
            ge     = EW'(rem_src) >= trial;
            rem_in = ge ? NW'(EW'(rem_src) - trial) : rem_src;
            q_in   = q_src;
            q_in[QW-1-j] = ge;
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
               den_ff[j] <= den_src;
               q_ff[j]   <= q_in;
               ovf_ff[j] <= ovf_src;
            end
         end
      end
   endgenerate

   assign quot = q_ff[QW-1];
   assign ovf  = ovf_ff[QW-1];

endmodule
`default_nettype wire

@@ sv/annular_current_ring_density.sv @@
// Annular current ring density: top level with configuration registers,
// geometry pipeline and three divider lanes. Uses acrd_pkg and acrd_div.
//
// Takes one Q4.12 point per cycle and returns one result per point, through five
// geometry stages (differences, products, sums, squares and scaled numerators,
// band compare and rounding offset), 24 divider stages that each settle one
// quotient bit, and the output register. The whole pipeline advances together
// and halts only while a result waits on rsp_tready. Configuration must be
// written while the pipeline is empty.
`default_nettype none
module annular_current_ring_density (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // point_x, point_y, point_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,  // density_x, density_y, density_z, inside_ring, pad
   input  wire logic        csr_we,
   input  wire logic [acrd_pkg::IDXW-1:0] csr_index,
   input  wire logic [acrd_pkg::RADW-1:0] csr_wdata
);
   localparam int CW   = acrd_pkg::CW;
   localparam int DW   = acrd_pkg::DW;
   localparam int PW   = acrd_pkg::PW;
   localparam int H2W  = acrd_pkg::H2W;
   localparam int TW   = acrd_pkg::TW;
   localparam int XW   = acrd_pkg::XW;
   localparam int MW   = acrd_pkg::MW;
   localparam int CCW  = acrd_pkg::CCW;
   localparam int RW   = acrd_pkg::RW;
   localparam int RSQW = acrd_pkg::RSQW;
   localparam int BW   = acrd_pkg::BW;
   localparam int NUMW = acrd_pkg::NUMW;
   localparam int DENW = acrd_pkg::DENW;
   localparam int NW   = acrd_pkg::NW;
   localparam int OW   = acrd_pkg::OW;
   localparam int QW   = acrd_pkg::QW;
   localparam int FRAC = acrd_pkg::FRAC;

   // ---------------- configuration ----------------
   logic [CW-1:0]   start_ff [3];
   logic [CW-1:0]   end_ff   [3];
   logic [acrd_pkg::RADW-1:0] radii_ff;
   logic [CW-1:0]   cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff[0] <= '0;
         start_ff[1] <= '0;
         start_ff[2] <= '0;
         end_ff[0]   <= acrd_pkg::END_X_RST;
         end_ff[1]   <= '0;
         end_ff[2]   <= '0;
         radii_ff    <= acrd_pkg::RADII_RST;
         cur_ff      <= acrd_pkg::CURRENT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            acrd_pkg::REG_START_X: start_ff[0] <= csr_wdata[CW-1:0];
            acrd_pkg::REG_START_Y: start_ff[1] <= csr_wdata[CW-1:0];
            acrd_pkg::REG_START_Z: start_ff[2] <= csr_wdata[CW-1:0];
            acrd_pkg::REG_END_X:   end_ff[0]   <= csr_wdata[CW-1:0];
            acrd_pkg::REG_END_Y:   end_ff[1]   <= csr_wdata[CW-1:0];
            acrd_pkg::REG_END_Z:   end_ff[2]   <= csr_wdata[CW-1:0];
            acrd_pkg::REG_RADII:   radii_ff    <= csr_wdata;
            acrd_pkg::REG_CURRENT: cur_ff      <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // radius terms derived from the registers, registered in the following cycle
   logic [RW-1:0]   r0, r1, ra, rb;
   logic [RSQW-1:0] rsq_lo_ff, rsq_hi_ff;
   logic [RW-1:0]   dr_ff;
   logic [CW-1:0]   cur_mag_ff;
   logic            cur_neg;

   always_comb begin
      r0 = radii_ff[RW-1:0];
      r1 = RW'(radii_ff[acrd_pkg::RADW-1:RW]);
      ra = (r0 < r1) ? r0 : r1;
      rb = (r0 < r1) ? r1 : r0;
      cur_neg = cur_ff[CW-1];
   end

   always_ff @(posedge clock) begin
      rsq_lo_ff  <= RSQW'(ra) * RSQW'(ra);
      rsq_hi_ff  <= RSQW'(rb) * RSQW'(rb);
      dr_ff      <= rb - ra;
      cur_mag_ff <= cur_neg ? CW'(-cur_ff) : cur_ff;
   end

   // ---------------- pipeline control ----------------
   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic vd_ff [QW];
   logic rsp_tvalid_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         for (int k = 0; k < QW; k++) vd_ff[k] <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vd_ff[0] <= v5_ff;
         for (int k = 1; k < QW; k++) vd_ff[k] <= vd_ff[k-1];
         rsp_tvalid_ff <= vd_ff[QW-1];
      end
   end

   // ---------------- stage 1: point relative to axis start ----------------
   logic signed [DW-1:0] ax [3];
   logic signed [DW-1:0] u1_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++)
         ax[k] = DW'($signed(end_ff[k])) - DW'($signed(start_ff[k]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++)
            u1_ff[k] <= DW'($signed(req_tdata[k*CW +: CW])) - DW'($signed(start_ff[k]));
      end
   end

   // ---------------- stage 2: products ----------------
   logic signed [PW-1:0] aa2_ff [3];
   logic signed [PW-1:0] au2_ff [3];
   logic signed [PW-1:0] xp2_ff [6];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            aa2_ff[k] <= PW'(ax[k]) * PW'(ax[k]);
            au2_ff[k] <= PW'(ax[k]) * PW'(u1_ff[k]);
         end
         xp2_ff[0] <= PW'(ax[1]) * PW'(u1_ff[2]);
         xp2_ff[1] <= PW'(ax[2]) * PW'(u1_ff[1]);
         xp2_ff[2] <= PW'(ax[2]) * PW'(u1_ff[0]);
         xp2_ff[3] <= PW'(ax[0]) * PW'(u1_ff[2]);
         xp2_ff[4] <= PW'(ax[0]) * PW'(u1_ff[1]);
         xp2_ff[5] <= PW'(ax[1]) * PW'(u1_ff[0]);
      end
   end

   // ---------------- stage 3: axis length, projection, cross product -------
   logic [H2W-1:0]       h2_3_ff;
   logic signed [TW-1:0] t3_ff;
   logic signed [XW-1:0] c3_ff [3];
   logic signed [TW-1:0] h2_sum;

   assign h2_sum = TW'(aa2_ff[0]) + TW'(aa2_ff[1]) + TW'(aa2_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         h2_3_ff <= h2_sum[H2W-1:0];
         t3_ff   <= TW'(au2_ff[0]) + TW'(au2_ff[1]) + TW'(au2_ff[2]);
         for (int k = 0; k < 3; k++)
            c3_ff[k] <= XW'(xp2_ff[2*k]) - XW'(xp2_ff[2*k+1]);
      end
   end

   // ---------------- stage 4: squares, bounds, numerators ----------------
   logic [MW-1:0]   cmag [3];
   logic [CCW-3:0]  csq4_ff [3];
   logic [BW-1:0]   lob4_ff, hib4_ff;
   logic [NUMW-1:0] num4_ff [3];
   logic [DENW-1:0] den4_ff;
   logic [2:0]      neg4_ff;
   logic            ok4_ff;

   always_comb begin
      for (int k = 0; k < 3; k++)
         cmag[k] = c3_ff[k][XW-1] ? MW'(-c3_ff[k]) : MW'(c3_ff[k]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            csq4_ff[k] <= (CCW-2)'(cmag[k]) * (CCW-2)'(cmag[k]);
            num4_ff[k] <= NUMW'(cur_mag_ff) * NUMW'(cmag[k]);
            neg4_ff[k] <= cur_neg != c3_ff[k][XW-1];
         end
         lob4_ff <= BW'(rsq_lo_ff) * BW'(h2_3_ff);
         hib4_ff <= BW'(rsq_hi_ff) * BW'(h2_3_ff);
         den4_ff <= DENW'(h2_3_ff) * DENW'(dr_ff);
         // axial span, and neither a zero-length axis nor equal radii
         ok4_ff  <= !t3_ff[TW-1] && (t3_ff <= $signed(TW'(h2_3_ff)))
                    && (h2_3_ff != '0) && (dr_ff != '0);
      end
   end

   // ---------------- stage 5: radial band, rounded dividend ----------------
   logic [CCW-1:0]  cc;
   logic            in5_ff;
   logic [NW-1:0]   n5_ff [3];
   logic [DENW-1:0] den5_ff;
   logic [2:0]      neg5_ff;

   assign cc = CCW'(csq4_ff[0]) + CCW'(csq4_ff[1]) + CCW'(csq4_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         in5_ff  <= ok4_ff && (CCW'(lob4_ff) <= cc) && (cc <= CCW'(hib4_ff));
         for (int k = 0; k < 3; k++)
            n5_ff[k] <= (NW'(num4_ff[k]) << FRAC) + NW'(den4_ff >> 1);
         den5_ff <= den4_ff;
         neg5_ff <= neg4_ff;
      end
   end

   // ---------------- divider lanes ----------------
   logic [QW-1:0] quot [3];
   logic          ovf  [3];

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_lane
         acrd_div u_div (
            .clock (clock),
            .en    (en),
            .num   (n5_ff[g]),
            .den   (den5_ff),
            .quot  (quot[g]),
            .ovf   (ovf[g])
         );
      end
   endgenerate

   acrd_pkg::side_type side_ff [QW];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= '{in_ring: in5_ff, neg: neg5_ff};
         for (int k = 1; k < QW; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // ---------------- output: sign and saturation ----------------
   logic [OW-1:0] dens [3];
   logic [OW-1:0] dens_ff [3];
   logic          inside_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (!side_ff[QW-1].in_ring) begin
            dens[k] = '0;
         end else if (side_ff[QW-1].neg[k]) begin
            dens[k] = (ovf[k] || quot[k] > acrd_pkg::NMAX) ? acrd_pkg::NMAX : OW'(-quot[k]);
         end else begin
            dens[k] = (ovf[k] || quot[k] > acrd_pkg::PMAX) ? acrd_pkg::PMAX : quot[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) dens_ff[k] <= dens[k];
         inside_ff <= side_ff[QW-1].in_ring;
      end
   end

   assign rsp_tdata = {7'd0, inside_ff, dens_ff[2], dens_ff[1], dens_ff[0]};

   // ---------------- assertions ----------------
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[72] |-> rsp_tdata[71:0] == '0)
      else $error("density non-zero outside the ring");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v1_ff)
      else $error("accepted request lost at the first stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v5_ff) && $stable(vd_ff[QW-1]))
      else $error("pipeline moved during a stall");

   a_zero_axis: assert property (@(posedge clock) disable iff (reset)
      en && v4_ff && den4_ff == '0 |=> !in5_ff)
      else $error("inside flag set with zero divisor");

endmodule
`default_nettype wire

@@ test/annular_current_ring_density_test.sv @@
// Testbench for the annular current ring density block: directed and random
// points under several ring settings, checked against an in-bench predictor.
// Depends on acrd_pkg and annular_current_ring_density.
`timescale 1ns / 100ps
`default_nettype none
module annular_current_ring_density_test;

   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_CYCLES = 1000000;

   typedef bit [127:0] wide_type;

   typedef struct packed {
      logic                    in_ring;
      logic [acrd_pkg::OW-1:0] dz;
      logic [acrd_pkg::OW-1:0] dy;
      logic [acrd_pkg::OW-1:0] dx;
   } density_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [47:0]      req_tdata = '0;   // point_x, point_y, point_z
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [79:0]      rsp_tdata;        // density_x, density_y, density_z, inside_ring, pad
   logic             csr_we = 1'b0;
   logic [acrd_pkg::IDXW-1:0] csr_index = '0;
   logic [acrd_pkg::RADW-1:0] csr_wdata = '0;

   bit [acrd_pkg::RADW-1:0] ring_regs [acrd_pkg::NREG];
   density_type      expected_densities [$];
   int               failures = 0;
   int               cycles = 0;
   int               rsp_stall = 0;
   bit               calm = 1'b0;

   annular_current_ring_density u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint coord(bit [acrd_pkg::RADW-1:0] v);
      return longint'($signed(v[acrd_pkg::CW-1:0]));
   endfunction

   function automatic logic [acrd_pkg::OW-1:0] scaled_density(longint cur, longint cv,
                                                               wide_type den);
      bit        neg;
      wide_type  num, q;
      neg = (cur < 0) != (cv < 0);
      num = (wide_type'(cur < 0 ? -cur : cur) * wide_type'(cv < 0 ? -cv : cv))
            << acrd_pkg::FRAC;
      if (num == 0) return '0;
      q = (num + den / 2) / den;
      if (neg) begin
         if (q > 128'(acrd_pkg::NMAX)) q = 128'(acrd_pkg::NMAX);
         return acrd_pkg::OW'(-q);
      end
      if (q > 128'(acrd_pkg::PMAX)) q = 128'(acrd_pkg::PMAX);
      return acrd_pkg::OW'(q);
   endfunction

   function automatic density_type ring_density(logic [47:0] pt);
      longint      a [3], u [3], c [3];
      longint      h2, t, r0, r1, ra, rb, cur;
      wide_type    cc, lo_b, hi_b, m, den;
      density_type res;
      h2 = 0;
      t = 0;
      res = '0;
      for (int k = 0; k < 3; k++) begin
         a[k] = coord(ring_regs[3 + k]) - coord(ring_regs[k]);
         u[k] = longint'($signed(pt[16*k +: 16])) - coord(ring_regs[k]);
         h2 += a[k] * a[k];
         t += a[k] * u[k];
      end
      r0 = longint'(ring_regs[acrd_pkg::REG_RADII][15:0]);
      r1 = longint'(ring_regs[acrd_pkg::REG_RADII][30:16]);
      ra = r0 < r1 ? r0 : r1;
      rb = r0 < r1 ? r1 : r0;
      if (h2 == 0 || ra == rb) return res;
      c[0] = a[1] * u[2] - a[2] * u[1];
      c[1] = a[2] * u[0] - a[0] * u[2];
      c[2] = a[0] * u[1] - a[1] * u[0];
      cc = '0;
      for (int k = 0; k < 3; k++) begin
         m = c[k] < 0 ? -c[k] : c[k];
         cc += m * m;
      end
      lo_b = wide_type'(ra * ra) * wide_type'(h2);
      hi_b = wide_type'(rb * rb) * wide_type'(h2);
      if (t < 0 || t > h2 || cc < lo_b || cc > hi_b) return res;
      cur = coord(ring_regs[acrd_pkg::REG_CURRENT]);
      den = wide_type'(h2) * wide_type'(rb - ra);
      res.dx = scaled_density(cur, c[0], den);
      res.dy = scaled_density(cur, c[1], den);
      res.dz = scaled_density(cur, c[2], den);
      res.in_ring = 1'b1;
      return res;
   endfunction

   // result side: stall drawn per result, compared while data is stable
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset;
      end
   end

   always @(negedge clock) begin
      density_type exp_d, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = density_type'(rsp_tdata[72:0]);
         if (expected_densities.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            failures++;
         end else begin
            exp_d = expected_densities.pop_front();
            if (got.dx !== exp_d.dx) begin
               $display("%0t: density_x expected %h actual %h", $time, exp_d.dx, got.dx);
               failures++;
            end
            if (got.dy !== exp_d.dy) begin
               $display("%0t: density_y expected %h actual %h", $time, exp_d.dy, got.dy);
               failures++;
            end
            if (got.dz !== exp_d.dz) begin
               $display("%0t: density_z expected %h actual %h", $time, exp_d.dz, got.dz);
               failures++;
            end
            if (got.in_ring !== exp_d.in_ring) begin
               $display("%0t: inside_ring expected %b actual %b", $time, exp_d.in_ring,
                        got.in_ring);
               failures++;
            end
         end
         rsp_stall = calm ? 0 : $urandom_range(0, 7);
      end
   end

   task automatic send_point(int x, int y, int z);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // valid stays high across back-to-back requests
      req_tvalid <= 1'b1;
      req_tdata <= {16'(z), 16'(y), 16'(x)};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      expected_densities.push_back(ring_density({16'(z), 16'(y), 16'(x)}));
   endtask

   // lets the pipeline run empty
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_densities.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [acrd_pkg::IDXW-1:0] idx, int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= acrd_pkg::RADW'(val);
      @(posedge clock);
      ring_regs[idx] = idx == acrd_pkg::REG_RADII ? acrd_pkg::RADW'(val)
                                                 : acrd_pkg::RADW'(val & 16'hffff);
   endtask

   task automatic set_ring(int sx, int sy, int sz, int ex, int ey, int ez,
                           int unsigned radii, int cur);
      drain();
      write_reg(acrd_pkg::REG_START_X, 16'(sx));
      write_reg(acrd_pkg::REG_START_Y, 16'(sy));
      write_reg(acrd_pkg::REG_START_Z, 16'(sz));
      write_reg(acrd_pkg::REG_END_X, 16'(ex));
      write_reg(acrd_pkg::REG_END_Y, 16'(ey));
      write_reg(acrd_pkg::REG_END_Z, 16'(ez));
      write_reg(acrd_pkg::REG_RADII, radii);
      write_reg(acrd_pkg::REG_CURRENT, 16'(cur));
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_ring();
      send_point(4096, 1229, 0);      // midway in the band
      send_point(0, 819, 0);          // start face, inner edge
      send_point(8192, 0, 1638);      // end face, outer edge
      send_point(8193, 1000, 0);      // just past the end
      send_point(-1, 1000, 0);        // just before the start
      send_point(4096, 0, 818);       // inside the hole
      send_point(-32768, -32768, -32768);
      send_point(32767, 32767, 32767);
   endtask

   task automatic test_special_rings();
      // radii swapped, negative current
      set_ring(0, 0, 0, 0, 0, 8192, (819 << 16) | 1638, -4096);
      send_point(1229, 0, 4096);
      send_point(-900, -900, 100);
      // equal radii
      set_ring(0, 0, 0, 8192, 0, 0, (1000 << 16) | 1000, 4096);
      send_point(4096, 1000, 0);
      // zero-length axis
      set_ring(100, -200, 300, 100, -200, 300, (1638 << 16) | 819, 4096);
      send_point(100, 1000, 300);
      // one-lsb axis and band, full current: saturates both ways
      set_ring(0, 0, 0, 1, 0, 0, (1 << 16) | 0, 32767);
      send_point(0, 1, 0);
      send_point(1, 0, -1);
      set_ring(0, 0, 0, 1, 0, 0, (1 << 16) | 0, -32768);
      send_point(0, 1, 0);
      send_point(0, -1, 0);
      // extreme axis and radii
      set_ring(-32768, -32768, -32768, 32767, 32767, 32767, 32'h7fffffff, 32767);
      send_point(0, 0, 0);
      send_point(32767, -32768, 0);
      send_point(-32768, 32767, 32767);
   endtask

   task automatic test_random_rings(int items);
      int sx, sy, sz, len, rb, ra, dir, px, py, pz, v [3];
      for (int n = 0; n < items; n++) begin
         if (n % 250 == 0) begin
            calm = $urandom_range(0, 3) == 0;
            sx = $urandom_range(0, 16384) - 8192;
            sy = $urandom_range(0, 16384) - 8192;
            sz = $urandom_range(0, 16384) - 8192;
            len = $urandom_range(1, 12000);
            rb = $urandom_range(1, 12000);
            ra = $urandom_range(0, rb);
            dir = $urandom_range(0, 3);
            v[0] = dir == 0 || dir == 3 ? len : 0;
            v[1] = dir == 1 || dir == 3 ? len / 2 : 0;
            v[2] = dir == 2 ? -len : 0;
            set_ring(sx, sy, sz, sx + v[0], sy + v[1], sz + v[2],
                     $urandom_range(0, 1) ? (rb << 16) | ra : (ra << 16) | rb,
                     $urandom_range(0, 65535) - 32768);
         end else if (n % 500 == 125) begin
            drain();
         end
         if ($urandom_range(0, 9) == 0) begin
            send_point($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 65535) - 32768);
         end else begin
            // along the axis, with a radial offset near the band
            px = sx + (v[0] * int'($urandom_range(0, 1100))) / 1000;
            py = sy + (v[1] * int'($urandom_range(0, 1100))) / 1000;
            pz = sz + (v[2] * int'($urandom_range(0, 1100))) / 1000;
            if (dir != 0) px += $urandom_range(0, 2 * rb) - rb;
            if (dir != 1) py += $urandom_range(0, 2 * rb) - rb;
            if (dir != 2) pz += $urandom_range(0, 2 * rb) - rb;
            send_point(px, py, pz);
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      for (int k = 0; k < acrd_pkg::NREG; k++) ring_regs[k] = '0;
      ring_regs[acrd_pkg::REG_END_X] = acrd_pkg::RADW'(acrd_pkg::END_X_RST);
      ring_regs[acrd_pkg::REG_RADII] = acrd_pkg::RADII_RST;
      ring_regs[acrd_pkg::REG_CURRENT] = acrd_pkg::RADW'(acrd_pkg::CURRENT_RST);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_ring();
      test_special_rings();
      test_random_rings(2000);
      drain();
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
